### hdl/battery_led_pattern_select_macros.svh
// assertion macros shared by the battery led pattern select checkers
`ifndef BATTERY_LED_PATTERN_SELECT_MACROS_SVH
`define BATTERY_LED_PATTERN_SELECT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BLPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/blps_pkg.sv
// types, constants and state selection for the battery led pattern select block
package blps_pkg;

    localparam int NUM_STATES = 10;
    localparam int TIME_BITS  = 8;

    localparam int SW = ($clog2(NUM_STATES + 1) > 4) ? $clog2(NUM_STATES + 1) : 4;
    localparam int AW = $clog2(NUM_STATES);

    localparam int COLOR_W  = 4;
    localparam int LEVEL_W  = 7;
    localparam int CHARGE_W = 10;
    localparam int PCT_W    = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;

    typedef logic [SW-1:0]        state_t;
    typedef logic [AW-1:0]        addr_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [COLOR_W-1:0]   color_t;

    // led state codes
    localparam state_t LS_LVL1        = state_t'(0);
    localparam state_t LS_LVL2        = state_t'(1);
    localparam state_t LS_FULL        = state_t'(2);
    localparam state_t LS_FULL_S5     = state_t'(3);
    localparam state_t LS_DIS_S0      = state_t'(4);
    localparam state_t LS_DIS_S0_LOW  = state_t'(5);
    localparam state_t LS_DIS_S3      = state_t'(6);
    localparam state_t LS_DIS_S5      = state_t'(7);
    localparam state_t LS_ERROR       = state_t'(8);
    localparam state_t LS_FACTORY     = state_t'(9);
    localparam state_t LS_NONE        = state_t'(NUM_STATES);

    // power state codes
    localparam logic [2:0] PWR_CHARGE         = 3'd0;
    localparam logic [2:0] PWR_DISCHARGE      = 3'd1;
    localparam logic [2:0] PWR_DISCHARGE_FULL = 3'd2;
    localparam logic [2:0] PWR_ERROR          = 3'd3;
    localparam logic [2:0] PWR_NEAR_FULL      = 3'd4;
    localparam logic [2:0] PWR_IDLE           = 3'd5;
    localparam logic [2:0] PWR_FORCED_IDLE    = 3'd6;
    localparam logic [2:0] PWR_OTHER          = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGER_ENABLED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_LEVEL_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_LEVEL_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATTERY_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATTERY_LEVEL  = 3'd4;

    typedef struct packed {
        logic               charger_enabled;
        logic [LEVEL_W-1:0] charge_level_one;
        logic [LEVEL_W-1:0] charge_level_two;
        logic               low_battery_enable;
        logic [LEVEL_W-1:0] low_battery_level;
    } cfg_t;

    // laid out as the low bits of s_tdata, power state lowest
    typedef struct packed {
        logic                external_power;
        logic                chipset_any_off;
        logic                chipset_any_suspend;
        logic                chipset_on;
        logic [CHARGE_W-1:0] display_charge;
        logic [2:0]          power_state;
    } tick_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        logic   phase;
        time_t  ptime;
        color_t color;
    } tbl_wr_t;

    typedef struct packed {
        time_t  t0;
        color_t c0;
        time_t  t1;
        color_t c1;
    } row_t;

    function automatic state_t pick_state(input tick_t t, input cfg_t c);
        logic [CHARGE_W:0]         rnd;
        logic [CHARGE_W+12:0]      prod;
        logic [PCT_W-1:0]          pct;
        state_t                    full_sel;
        state_t                    dis_sel;
        state_t                    s;
        // (permille + 5) / 10 as a multiply by 3277 / 2^15
        rnd  = {1'b0, t.display_charge} + (CHARGE_W+1)'(5);
        prod = (CHARGE_W+13)'(rnd) * (CHARGE_W+13)'(3277);
        pct  = prod[CHARGE_W+12:15];
        full_sel = t.chipset_any_off ? LS_FULL_S5 : LS_FULL;
        if (t.chipset_on) begin
            if (c.low_battery_enable && (pct < {1'b0, c.low_battery_level})) begin
                dis_sel = LS_DIS_S0_LOW;
            end else begin
                dis_sel = LS_DIS_S0;
            end
        end else begin
            dis_sel = t.chipset_any_suspend ? LS_DIS_S3 : LS_DIS_S5;
        end
        s = LS_NONE;
        if (c.charger_enabled) begin
            unique case (t.power_state) inside
                PWR_CHARGE: begin
                    if (pct < {1'b0, c.charge_level_one}) begin
                        s = LS_LVL1;
                    end else if (pct < {1'b0, c.charge_level_two}) begin
                        s = LS_LVL2;
                    end else begin
                        s = full_sel;
                    end
                end
                PWR_DISCHARGE, PWR_DISCHARGE_FULL: begin
                    if ((t.power_state == PWR_DISCHARGE_FULL) && t.external_power) begin
                        s = full_sel;
                    end else begin
                        s = dis_sel;
                    end
                end
                PWR_ERROR:       s = LS_ERROR;
                PWR_NEAR_FULL:   s = full_sel;
                PWR_IDLE:        s = t.chipset_any_off ? LS_DIS_S5 : LS_DIS_S0;
                PWR_FORCED_IDLE: s = LS_FACTORY;
                default:         s = LS_NONE;
            endcase
        end
        return s;
    endfunction

    function automatic addr_t state_addr(input state_t s);
        return (s < state_t'(NUM_STATES)) ? s[AW-1:0] : '0;
    endfunction

endpackage

### hdl/blps_tbl.sv
// two-phase pattern table: one memory per phase with valid bits cleared by reset
module blps_tbl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  blps_pkg::tbl_wr_t     wr,
    input  blps_pkg::addr_t       rd_addr,
    output blps_pkg::row_t        rd_row
);

    typedef struct packed {
        blps_pkg::time_t  ptime;
        blps_pkg::color_t color;
    } entry_t;

    entry_t mem0 [blps_pkg::NUM_STATES];
    entry_t mem1 [blps_pkg::NUM_STATES];

    logic [blps_pkg::NUM_STATES-1:0] vld0_reg;
    logic [blps_pkg::NUM_STATES-1:0] vld1_reg;

    entry_t rd0_reg;
    entry_t rd1_reg;
    logic   rv0_reg;
    logic   rv1_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            if (wr.phase) begin
                mem1[wr.addr] <= '{ptime: wr.ptime, color: wr.color};
            end else begin
                mem0[wr.addr] <= '{ptime: wr.ptime, color: wr.color};
            end
        end
        rd0_reg <= mem0[rd_addr];
        rd1_reg <= mem1[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= '0;
            vld1_reg <= '0;
            rv0_reg  <= 1'b0;
            rv1_reg  <= 1'b0;
        end else begin
            if (wr.en && !wr.phase) begin
                vld0_reg[wr.addr] <= 1'b1;
            end
            if (wr.en && wr.phase) begin
                vld1_reg[wr.addr] <= 1'b1;
            end
            rv0_reg <= vld0_reg[rd_addr];
            rv1_reg <= vld1_reg[rd_addr];
        end
    end

    // an entry never written reads as zero
    assign rd_row.t0 = rv0_reg ? rd0_reg.ptime : '0;
    assign rd_row.c0 = rv0_reg ? rd0_reg.color : '0;
    assign rd_row.t1 = rv1_reg ? rd1_reg.ptime : '0;
    assign rd_row.c1 = rv1_reg ? rd1_reg.color : '0;

endmodule

### hdl/battery_led_pattern_select.sv
// battery led pattern select top level: state choice, tick counter and result register
//
//  channel  direction  words
//  s_       in         tuser: cmd; tdata: tick flags and table entry
//  m_       out        tdata: led color, undefined flag, state, phase
//  cfg_     in         index and data of one configuration register
//
//  a table write leaves the block idle; a tick goes through pick and emit, with a
//  check step between them when the state changes, repeated when full-in-S5 falls
//  back to full charge (one table read per step, one read port per phase memory)
//  reset clears the table valid bits directly, no sweep
//  a result waits in the output register while the next word is accepted
//  cfg writes are always ready
module battery_led_pattern_select (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [0:0]                      s_tuser,  // cmd
    // power_state, display_charge, chipset_on, chipset_any_suspend,
    // chipset_any_off, external_power, entry_state, entry_phase, entry_time,
    // entry_color, zero pad
    input  logic [blps_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // led_color, pattern_undefined, active_state, active_phase, zero pad
    output logic [blps_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [blps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blps_pkg::CFG_DAT_W-1:0]  cfg_data
);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_PICK = 2'd1;
    localparam logic [1:0] FS_CHK  = 2'd2;
    localparam logic [1:0] FS_EMIT = 2'd3;

    logic [1:0]                       fsm_reg, fsm_next;
    blps_pkg::cfg_t                   cfg_reg;
    blps_pkg::tick_t                  item_reg;
    blps_pkg::state_t                 cur_reg, cur_next;
    blps_pkg::state_t                 want_reg, want_next;
    blps_pkg::time_t                  tick_reg, tick_next;
    blps_pkg::time_t                  period_reg, period_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [blps_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    blps_pkg::tbl_wr_t                wr;
    blps_pkg::addr_t                  rd_addr;
    blps_pkg::row_t                   row;

    blps_pkg::state_t                 want_c;
    logic                             enter_c;
    logic                             fallback_c;
    logic                             s_acc;
    logic                             out_free;
    logic                             undef_c;
    logic                             phase_c;
    logic [blps_pkg::TIME_BITS:0]     tick_inc;
    blps_pkg::color_t                 color_c;

    assign s_tready  = (fsm_reg == FS_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // table writes
    always_comb begin
        wr.en    = s_acc && s_tuser[0] && (s_tdata[20:17] < blps_pkg::NUM_STATES);
        wr.addr  = blps_pkg::addr_t'(s_tdata[20:17]);
        wr.phase = s_tdata[21];
        wr.ptime = blps_pkg::time_t'(s_tdata[29:22]);
        wr.color = s_tdata[33:30];
    end

    blps_tbl u_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_row  (row)
    );

    assign want_c     = blps_pkg::pick_state(item_reg, cfg_reg);
    assign enter_c    = (want_c < blps_pkg::state_t'(blps_pkg::NUM_STATES)) &&
                        (want_c != cur_reg);
    assign fallback_c = (want_reg == blps_pkg::LS_FULL_S5) && (row.t0 == '0);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign undef_c    = (period_reg == '0) ||
                        (cur_reg >= blps_pkg::state_t'(blps_pkg::NUM_STATES));
    assign phase_c    = !(tick_reg < row.t0);
    assign tick_inc   = {1'b0, tick_reg} + (blps_pkg::TIME_BITS+1)'(1);
    assign color_c    = phase_c ? row.c1 : row.c0;

    always_comb begin
        unique case (fsm_reg)
            FS_PICK: rd_addr = enter_c ? blps_pkg::state_addr(want_c)
                                       : blps_pkg::state_addr(cur_reg);
            FS_CHK:  rd_addr = fallback_c ? blps_pkg::state_addr(blps_pkg::LS_FULL)
                                          : blps_pkg::state_addr(want_reg);
            default: rd_addr = blps_pkg::state_addr(cur_reg);
        endcase
    end

    always_comb begin
        fsm_next      = fsm_reg;
        cur_next      = cur_reg;
        want_next     = want_reg;
        tick_next     = tick_reg;
        period_next   = period_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (fsm_reg)
            FS_IDLE: begin
                if (s_acc && !s_tuser[0]) begin
                    fsm_next = FS_PICK;
                end
            end
            FS_PICK: begin
                want_next = want_c;
                fsm_next  = enter_c ? FS_CHK : FS_EMIT;
            end
            FS_CHK: begin
                if (fallback_c) begin
                    want_next = blps_pkg::LS_FULL;
                end else begin
                    cur_next    = want_reg;
                    tick_next   = '0;
                    period_next = row.t0 + row.t1;
                    fsm_next    = FS_EMIT;
                end
            end
            FS_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (undef_c) begin
                        m_tdata_next = {6'b0, 1'b0, 4'(cur_reg), 1'b1, 4'b0};
                    end else begin
                        m_tdata_next = {6'b0, phase_c, 4'(cur_reg), 1'b0, color_c};
                        tick_next = (tick_inc == {1'b0, period_reg}) ? '0
                                  : tick_inc[blps_pkg::TIME_BITS-1:0];
                    end
                    fsm_next = FS_IDLE;
                end
            end
            default: fsm_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= FS_IDLE;
            cur_reg      <= blps_pkg::LS_NONE;
            tick_reg     <= '0;
            period_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            fsm_reg      <= fsm_next;
            cur_reg      <= cur_next;
            tick_reg     <= tick_next;
            period_reg   <= period_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        want_reg    <= want_next;
        m_tdata_reg <= m_tdata_next;
        if (s_acc) begin
            item_reg <= s_tdata[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{charger_enabled: 1'b1, default: '0};
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                blps_pkg::CFG_CHARGER_ENABLED:    cfg_reg.charger_enabled    <= cfg_data[0];
                blps_pkg::CFG_CHARGE_LEVEL_ONE:   cfg_reg.charge_level_one   <= cfg_data;
                blps_pkg::CFG_CHARGE_LEVEL_TWO:   cfg_reg.charge_level_two   <= cfg_data;
                blps_pkg::CFG_LOW_BATTERY_ENABLE: cfg_reg.low_battery_enable <= cfg_data[0];
                blps_pkg::CFG_LOW_BATTERY_LEVEL:  cfg_reg.low_battery_level  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### hdl/blps_chk.sv
// port checker for the battery led pattern select block
`include "battery_led_pattern_select_macros.svh"

module blps_chk (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [blps_pkg::M_TDATA_W-1:0]  m_tdata
);

    `BLPS_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled word changed")
    `BLPS_ASSERT_SAME(a_undef_off, m_tvalid && m_tdata[4], (m_tdata[3:0] == 4'd0) && !m_tdata[9], "undefined pattern not off")
    `BLPS_ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && !s_tuser[0], !s_tready, "tick word not held off")
    `BLPS_ASSERT_NEXT(a_write_silent, s_tvalid && s_tready && s_tuser[0] && !m_tvalid, !m_tvalid, "table write made a word")

endmodule

bind battery_led_pattern_select blps_chk u_blps_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
